// File: sv/qss_pkg.sv
// qss_pkg: shared types and constants for the quicksort sorter core
// no dependencies; imported by quicksort_sorter_core
package qss_pkg;

    localparam int VALUE_W       = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_POP,
        S_POPW,
        S_PIV,
        S_LRD,
        S_LCMP,
        S_RRD,
        S_RCMP,
        S_SWL,
        S_SWR,
        S_CHK,
        S_PUSH1,
        S_PUSH2,
        S_OUT,
        S_DONE
    } t_state;

endpackage

// File: sv/quicksort_sorter_core.sv
// quicksort_sorter_core: load, in-place quicksort and ordered read-out of signed values
// depends on qss_pkg and qss_ram
//
// Usage:
//   Input channel: an item transfers at a rising edge with i_start high and o_busy low.
//   Items load one per cycle into the element store (MAX_ITEMS entries). Items beyond
//   capacity are dropped and the run is flagged as overflowed.
//   An item with is_last set ends the list: o_busy rises and the store is sorted by
//   Hoare-partition quicksort, middle element as pivot, with a stack of index ranges
//   held in a second memory.
//   Sort time is set by the single read port of the element store: a scan step is a
//   read and a compare, a swap writes both values, each range pops bounds and reads a pivot.
//   Output: the n sorted values follow on o_result, one per cycle, each marked by
//   o_valid for exactly one cycle; last_out marks the final one and overflow is the
//   same on all of them. Each result is read from the store and registered; o_busy falls
//   the cycle after the last result.
//   The receiver cannot stall; results are never held.
//   Reset (synchronous, active low) empties the store, the overflow flag and the
//   stack; memory contents are not cleared and no clearing pass is needed.
module quicksort_sorter_core
    import qss_pkg::*;
#(
    parameter int MAX_ITEMS = qss_pkg::MAX_ITEMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  qss_pkg::t_in_item    i_item,
    output logic                 o_busy,
    output logic                 o_valid,
    output qss_pkg::t_out_item   o_result
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    t_state r_state, n_state;

    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_ovf, n_ovf;
    logic [CNT_W-1:0]        r_sp, n_sp;
    logic [IDX_W-1:0]        r_lo, n_lo;
    logic [IDX_W-1:0]        r_hi, n_hi;
    logic signed [CNT_W:0]   r_l, n_l;
    logic signed [CNT_W:0]   r_r, n_r;
    logic [VALUE_W-1:0]      r_piv, n_piv;
    logic [VALUE_W-1:0]      r_vl, n_vl;
    logic [VALUE_W-1:0]      r_vr, n_vr;
    logic [IDX_W-1:0]        r_i, n_i;
    logic                    r_oval, n_oval;
    logic                    r_olast, n_olast;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [VALUE_W-1:0]      mem_wdata;
    logic [IDX_W-1:0]        mem_raddr;
    logic [VALUE_W-1:0]      mem_rdata;

    logic                    st_we;
    logic [IDX_W-1:0]        st_waddr;
    logic [2*IDX_W-1:0]      st_wdata;
    logic [IDX_W-1:0]        st_raddr;
    logic [2*IDX_W-1:0]      st_rdata;

    logic [IDX_W-1:0]        st_lo, st_hi;
    logic [IDX_W:0]          mid_sum;
    logic signed [CNT_W:0]   lo_s, hi_s;
    logic                    l_adv, r_adv;
    logic                    sp_full;

    qss_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    qss_ram #(
        .WIDTH (2 * IDX_W),
        .DEPTH (MAX_ITEMS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign st_lo   = st_rdata[2*IDX_W-1:IDX_W];
    assign st_hi   = st_rdata[IDX_W-1:0];
    assign mid_sum = {1'b0, st_lo} + {1'b0, st_hi};
    assign lo_s    = $signed({{(CNT_W + 1 - IDX_W){1'b0}}, r_lo});
    assign hi_s    = $signed({{(CNT_W + 1 - IDX_W){1'b0}}, r_hi});
    assign l_adv   = (r_l < hi_s) && ($signed(mem_rdata) < $signed(r_piv));
    assign r_adv   = (r_r > lo_s) && ($signed(r_piv) < $signed(mem_rdata));
    assign sp_full = (r_sp >= CNT_W'(MAX_ITEMS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_item.is_last) begin
                    n_state = (n_cnt < CNT_W'(2)) ? S_OUT : S_INIT;
                end
            end
            S_INIT:  n_state = S_POP;
            S_POP:   n_state = (r_sp == '0) ? S_OUT : S_POPW;
            S_POPW: begin
                if ((st_lo >= st_hi) || (CNT_W'(st_hi) >= r_cnt)) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_PIV;
                end
            end
            S_PIV:   n_state = S_LRD;
            S_LRD:   n_state = S_LCMP;
            S_LCMP:  n_state = l_adv ? S_LRD : S_RRD;
            S_RRD:   n_state = S_RCMP;
            S_RCMP: begin
                if (r_adv) begin
                    n_state = S_RRD;
                end else if (r_l <= r_r) begin
                    n_state = S_SWL;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_SWL:   n_state = S_SWR;
            S_SWR:   n_state = S_CHK;
            S_CHK:   n_state = (r_l <= r_r) ? S_LRD : S_PUSH1;
            S_PUSH1: n_state = S_PUSH2;
            S_PUSH2: n_state = S_POP;
            S_OUT: begin
                if (r_i == IDX_W'(r_cnt - CNT_W'(1))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_sp      = r_sp;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_l       = r_l;
        n_r       = r_r;
        n_piv     = r_piv;
        n_vl      = r_vl;
        n_vr      = r_vr;
        n_i       = r_i;
        mem_we    = 1'b0;
        mem_waddr = r_l[IDX_W-1:0];
        mem_wdata = r_vr;
        mem_raddr = r_l[IDX_W-1:0];
        st_we     = 1'b0;
        st_waddr  = r_sp[IDX_W-1:0];
        st_wdata  = {r_lo, r_r[IDX_W-1:0]};
        st_raddr  = IDX_W'(r_sp - CNT_W'(1));
        case (r_state)
            S_IDLE: begin
                n_i = '0;
                if (i_start) begin
                    if (r_cnt < CNT_W'(MAX_ITEMS)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_cnt[IDX_W-1:0];
                        mem_wdata = i_item.value;
                        n_cnt     = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_INIT: begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = {{IDX_W{1'b0}}, IDX_W'(r_cnt - CNT_W'(1))};
                n_sp     = CNT_W'(1);
            end
            S_POP: begin
                if (r_sp != '0) begin
                    n_sp = r_sp - CNT_W'(1);
                end
            end
            S_POPW: begin
                n_lo      = st_lo;
                n_hi      = st_hi;
                n_l       = $signed({{(CNT_W + 1 - IDX_W){1'b0}}, st_lo});
                n_r       = $signed({{(CNT_W + 1 - IDX_W){1'b0}}, st_hi});
                mem_raddr = mid_sum[IDX_W:1];
            end
            S_PIV: begin
                n_piv = mem_rdata;
            end
            S_LRD: begin
                mem_raddr = r_l[IDX_W-1:0];
            end
            S_LCMP: begin
                if (l_adv) begin
                    n_l = r_l + (CNT_W + 1)'(1);
                end else begin
                    n_vl = mem_rdata;
                end
            end
            S_RRD: begin
                mem_raddr = r_r[IDX_W-1:0];
            end
            S_RCMP: begin
                if (r_adv) begin
                    n_r = r_r - (CNT_W + 1)'(1);
                end else begin
                    n_vr = mem_rdata;
                end
            end
            S_SWL: begin
                mem_we    = 1'b1;
                mem_waddr = r_l[IDX_W-1:0];
                mem_wdata = r_vr;
            end
            S_SWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_r[IDX_W-1:0];
                mem_wdata = r_vl;
                n_l       = r_l + (CNT_W + 1)'(1);
                n_r       = r_r - (CNT_W + 1)'(1);
            end
            S_PUSH1: begin
                if ((lo_s < r_r) && !sp_full) begin
                    st_we    = 1'b1;
                    st_wdata = {r_lo, r_r[IDX_W-1:0]};
                    n_sp     = r_sp + CNT_W'(1);
                end
            end
            S_PUSH2: begin
                if ((r_l < hi_s) && !sp_full) begin
                    st_we    = 1'b1;
                    st_wdata = {r_l[IDX_W-1:0], r_hi};
                    n_sp     = r_sp + CNT_W'(1);
                end
            end
            S_OUT: begin
                mem_raddr = r_i;
                n_i       = r_i + IDX_W'(1);
            end
            S_DONE: begin
                n_cnt = '0;
                n_ovf = 1'b0;
                n_sp  = '0;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy                = (r_state != S_IDLE);
        n_oval                = (r_state == S_OUT);
        n_olast               = (r_state == S_OUT) && (n_state == S_DONE);
        o_valid               = r_oval;
        o_result.sorted_value = mem_rdata;
        o_result.last_out     = r_olast;
        o_result.overflow     = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
            r_oval  <= 1'b0;
            r_olast <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
            r_oval  <= n_oval;
            r_olast <= n_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_l   <= n_l;
        r_r   <= n_r;
        r_piv <= n_piv;
        r_vl  <= n_vl;
        r_vr  <= n_vr;
        r_i   <= n_i;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(MAX_ITEMS))
        else $error("range stack pointer beyond depth");

    a_l_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LRD) |-> ((r_l >= lo_s) && (r_l <= hi_s)))
        else $error("left scan index left its range");

    a_r_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RRD) |-> ((r_r >= lo_s) && (r_r <= hi_s)))
        else $error("right scan index left its range");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_out) |=> (r_state == S_IDLE))
        else $error("final result not followed by idle");

endmodule

// File: sv/qss_ram.sv
// qss_ram: single write port, single registered read port memory
// no dependencies; used for the element store and the range stack
module qss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
